FILE: rtl/core/mgcpm_pkg.sv
package mgcpm_pkg;

   // Operation codes of an input item
   localparam logic [2:0] OP_PAIR  = 3'd0;
   localparam logic [2:0] OP_VOL   = 3'd1;
   localparam logic [2:0] OP_START = 3'd2;
   localparam logic [2:0] OP_END   = 3'd3;
   localparam logic [2:0] OP_STOP  = 3'd4;

   // Fixed field widths
   localparam int GAIN_W      = 10;
   localparam int GAIN_FRAC_W = 8;
   localparam int VOL_W       = 8;
   localparam int OUT_W       = 26;
   localparam int PEAK_W      = 25;
   localparam int COUNT_W     = 32;
   localparam int NUM_W       = 27;   // 2*gain*32767 + |value|
   localparam int DSH_W       = 35;   // 2*|value| shifted up by 9

   localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;
   localparam int FULL_SCALE  = 32767;
   localparam int OUT_LIMIT   = 33554431;

   // Restoring divide produces one gain bit per step
   localparam int DIV_STEPS   = GAIN_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // capture an accepted item
      logic mul_en;     // register sample times gain
      logic chan_r;     // 0 left channel, 1 right channel
      logic post_en;    // shift, saturate, track peak, prepare divide
      logic div_step;   // one restoring divide step
      logic div_last;   // final step, write new gain
      logic exec_en;    // run a non-sample operation
      logic out_load;   // snapshot the result into the output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic req_pair;   // offered item is a sample pair
      logic div_need;   // last post step found clipping
   } status_type;

endpackage

FILE: rtl/core/mgcpm_req_if.sv
interface mgcpm_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    operation;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   logic [7:0]                    volume;
   logic                          meter_was_read;

   modport source (
      output valid, operation, left_in, right_in, volume, meter_was_read,
      input  ready
   );
   modport sink (
      input  valid, operation, left_in, right_in, volume, meter_was_read,
      output ready
   );
endinterface

FILE: rtl/core/mgcpm_rsp_if.sv
interface mgcpm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [25:0] left_out;
   logic signed [25:0] right_out;
   logic [9:0]         gain_now;
   logic [24:0]        left_peak_now;
   logic [24:0]        right_peak_now;
   logic [24:0]        overall_peak_now;
   logic               clipped;
   logic [31:0]        pairs_counted;

   modport source (
      output valid, left_out, right_out, gain_now, left_peak_now, right_peak_now,
             overall_peak_now, clipped, pairs_counted,
      input  ready
   );
   modport sink (
      input  valid, left_out, right_out, gain_now, left_peak_now, right_peak_now,
             overall_peak_now, clipped, pairs_counted,
      output ready
   );
endinterface

FILE: rtl/core/mgcpm_ctrl.sv
module mgcpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mgcpm_pkg::status_type  status,
   output mgcpm_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_L, S_POST_L, S_CHK_L, S_DIV_L,
      S_MUL_R, S_POST_R, S_CHK_R, S_DIV_R, S_EXEC, S_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [mgcpm_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                              valid_ff, valid_in;
   logic                              accept;
   logic                              cnt_last;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = valid_ff;
   assign cnt_last  = (cnt_ff == mgcpm_pkg::DIV_CNT_W'(mgcpm_pkg::DIV_STEPS - 1));

   // Decode commands from state
   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.mul_en   = (state_ff == S_MUL_L) || (state_ff == S_MUL_R);
      cmd.post_en  = (state_ff == S_POST_L) || (state_ff == S_POST_R);
      cmd.chan_r   = (state_ff == S_MUL_R) || (state_ff == S_POST_R) ||
                     (state_ff == S_DIV_R);
      cmd.div_step = (state_ff == S_DIV_L) || (state_ff == S_DIV_R);
      cmd.div_last = cmd.div_step && cnt_last;
      cmd.exec_en  = (state_ff == S_EXEC);
      cmd.out_load = (state_ff == S_DONE) && (!valid_ff || rsp_ready);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = status.req_pair ? S_MUL_L : S_EXEC;
         end
         S_MUL_L:  state_in = S_POST_L;
         S_POST_L: state_in = S_CHK_L;
         S_CHK_L: begin
            cnt_in   = '0;
            state_in = status.div_need ? S_DIV_L : S_MUL_R;
         end
         S_DIV_L: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) state_in = S_MUL_R;
         end
         S_MUL_R:  state_in = S_POST_R;
         S_POST_R: state_in = S_CHK_R;
         S_CHK_R: begin
            cnt_in   = '0;
            state_in = status.div_need ? S_DIV_R : S_DONE;
         end
         S_DIV_R: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) state_in = S_DONE;
         end
         S_EXEC: state_in = S_DONE;
         S_DONE: begin
            if (cmd.out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold output valid until taken
   assign valid_in = cmd.out_load || (valid_ff && !rsp_ready);

   // Advance state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // A waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |-> !cmd.out_load)
      else $error("result overwritten before taken");

   // Divide runs no more than its step count
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (cnt_ff < mgcpm_pkg::DIV_CNT_W'(mgcpm_pkg::DIV_STEPS)))
      else $error("divide step count overrun");

   // Last divide step always leads to the next channel or the result
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      cmd.div_last |=> (state_ff == S_MUL_R || state_ff == S_DONE))
      else $error("divide did not finish cleanly");

endmodule

FILE: rtl/core/mgcpm_dpath.sv
module mgcpm_dpath #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mgcpm_pkg::cmd_type            cmd,
   output mgcpm_pkg::status_type         status,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic [2:0]                    req_operation,
   input  logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [SAMPLE_BITS-1:0] req_right_in,
   input  logic [7:0]                    req_volume,
   input  logic                          req_meter_was_read,
   output logic signed [25:0]            rsp_left_out,
   output logic signed [25:0]            rsp_right_out,
   output logic [9:0]                    rsp_gain_now,
   output logic [24:0]                   rsp_left_peak_now,
   output logic [24:0]                   rsp_right_peak_now,
   output logic [24:0]                   rsp_overall_peak_now,
   output logic                          rsp_clipped,
   output logic [31:0]                   rsp_pairs_counted
);

   localparam int GW  = mgcpm_pkg::GAIN_W;
   localparam int PKW = mgcpm_pkg::PEAK_W;
   localparam int OW  = mgcpm_pkg::OUT_W;
   localparam int NW  = mgcpm_pkg::NUM_W;
   localparam int DW  = mgcpm_pkg::DSH_W;
   localparam int FW  = mgcpm_pkg::GAIN_FRAC_W;
   localparam int PW  = SAMPLE_BITS + GW + 1;   // signed product
   localparam int VW  = PW - FW;                // product after the fraction shift
   localparam int CW  = (VW > OW + 1) ? VW : OW + 1;

   localparam logic signed [CW-1:0] POS_LIM = CW'(mgcpm_pkg::OUT_LIMIT);
   localparam logic signed [CW-1:0] NEG_LIM = -POS_LIM;
   localparam logic signed [OW-1:0] POS_FS  = OW'(mgcpm_pkg::FULL_SCALE);
   localparam logic signed [OW-1:0] NEG_FS  = -POS_FS;
   localparam logic [PKW-1:0]       PK_FS   = PKW'(mgcpm_pkg::FULL_SCALE);
   localparam logic [PKW-1:0]       PK_ONE  = PKW'(1);
   localparam logic [NW-1:0]        TWO_FS  = NW'(2 * mgcpm_pkg::FULL_SCALE);
   localparam logic signed [PW-1:0] FRAC_MASK = PW'((1 << FW) - 1);

   // Item and state registers
   logic [2:0]                    op_ff;
   logic signed [SAMPLE_BITS-1:0] lsamp_ff, rsamp_ff;
   logic [7:0]                    vol_ff;
   logic                          mwr_ff;
   logic                          dec_ff;
   logic [GW-1:0]                 gain_ff;
   logic [PKW-1:0]                lpk_ff, rpk_ff, opk_ff;
   logic                          clip_ff;
   logic [31:0]                   cnt_ff;
   logic signed [OW-1:0]          lout_ff, rout_ff;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic [NW-1:0]                 rem_ff, rem_in, num_in;
   logic [DW-1:0]                 dsh_ff;
   logic [GW-2:0]                 quot_ff;
   logic                          need_ff, need_in;

   logic signed [SAMPLE_BITS-1:0] mul_a;
   logic signed [PW-1:0]          adj;
   logic signed [VW-1:0]          vsh;
   logic signed [CW-1:0]          vx, vsat;
   logic signed [OW-1:0]          vs, vout;
   logic [OW-1:0]                 vabs;
   logic [PKW-1:0]                mag, cur_pk;
   logic                          ge;
   logic [PKW-1:0]                lend, rend, pk_max;
   logic                          lclip, rclip;

   assign status.req_pair = (req_operation == mgcpm_pkg::OP_PAIR);
   assign status.div_need = need_ff;

   // Multiply the selected sample by the gain
   assign mul_a   = cmd.chan_r ? rsamp_ff : lsamp_ff;
   assign prod_in = PW'(mul_a) * PW'($signed({1'b0, gain_ff}));

   // Drop fraction bits toward zero, then saturate
   assign adj  = prod_ff + (prod_ff[PW-1] ? FRAC_MASK : '0);
   assign vsh  = adj[PW-1:FW];
   assign vx   = CW'(vsh);
   always_comb begin
      priority if (vx > POS_LIM) vsat = POS_LIM;
      else if (vx < NEG_LIM)     vsat = NEG_LIM;
      else                       vsat = vx;
   end
   assign vs      = OW'(vsat);
   assign vabs    = vs[OW-1] ? OW'(-vs) : OW'(vs);
   assign mag     = vabs[PKW-1:0];
   assign cur_pk  = cmd.chan_r ? rpk_ff : lpk_ff;
   assign need_in = dec_ff && (mag > PK_FS);
   assign vout    = need_in ? (vs[OW-1] ? NEG_FS : POS_FS) : vs;

   // Numerator of the rounded gain ratio
   assign num_in = NW'(gain_ff) * TWO_FS + NW'(mag);

   // One restoring divide step
   assign ge     = ({{(DW-NW){1'b0}}, rem_ff} >= dsh_ff);
   assign rem_in = ge ? NW'({{(DW-NW){1'b0}}, rem_ff} - dsh_ff) : rem_ff;

   // Block end clamp of both peaks
   always_comb begin
      lclip = (lpk_ff > PK_FS);
      rclip = (rpk_ff > PK_FS);
      lend  = lclip ? PK_FS : ((lpk_ff == '0) ? PK_ONE : lpk_ff);
      rend  = rclip ? PK_FS : ((rpk_ff == '0) ? PK_ONE : rpk_ff);
      pk_max = opk_ff;
      if (lend > pk_max) pk_max = lend;
      if (rend > pk_max) pk_max = rend;
   end

   // Capture item and run the arithmetic pipeline
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         lsamp_ff <= req_left_in;
         rsamp_ff <= req_right_in;
         vol_ff   <= req_volume;
         mwr_ff   <= req_meter_was_read;
         lout_ff  <= '0;
         rout_ff  <= '0;
      end else if (cmd.post_en) begin
         if (cmd.chan_r) rout_ff <= vout;
         else            lout_ff <= vout;
      end
      if (cmd.mul_en) prod_ff <= prod_in;
      if (cmd.post_en) begin
         rem_ff <= num_in;
         dsh_ff <= DW'({mag, 1'b0}) << (GW - 1);
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         dsh_ff  <= dsh_ff >> 1;
         quot_ff <= {quot_ff[GW-3:0], ge};
      end
   end

   // Hold the block state
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff  <= 1'b0;
         gain_ff <= mgcpm_pkg::GAIN_RESET;
         lpk_ff  <= PK_ONE;
         rpk_ff  <= PK_ONE;
         opk_ff  <= '0;
         clip_ff <= 1'b0;
         cnt_ff  <= '0;
         need_ff <= 1'b0;
      end else begin
         if (csr_wr_en) dec_ff <= csr_wr_data;
         if (cmd.post_en) begin
            need_ff <= need_in;
            if (mag > cur_pk) begin
               if (cmd.chan_r) rpk_ff <= mag;
               else            lpk_ff <= mag;
            end
            if (cmd.chan_r) cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.div_last) gain_ff <= {quot_ff, ge};
         if (cmd.exec_en) begin
            unique case (op_ff)
               mgcpm_pkg::OP_VOL: gain_ff <= GW'(vol_ff);
               mgcpm_pkg::OP_START: begin
                  if (mwr_ff) begin
                     lpk_ff <= lpk_ff >> 1;
                     rpk_ff <= rpk_ff >> 1;
                  end
               end
               mgcpm_pkg::OP_END: begin
                  lpk_ff <= lend;
                  rpk_ff <= rend;
                  opk_ff <= pk_max;
                  if (lclip || rclip) clip_ff <= 1'b1;
               end
               mgcpm_pkg::OP_STOP: begin
                  clip_ff <= 1'b0;
                  cnt_ff  <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   // Snapshot the result for the output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_left_out         <= lout_ff;
         rsp_right_out        <= rout_ff;
         rsp_gain_now         <= gain_ff;
         rsp_left_peak_now    <= lpk_ff;
         rsp_right_peak_now   <= rpk_ff;
         rsp_overall_peak_now <= opk_ff;
         rsp_clipped          <= clip_ff;
         rsp_pairs_counted    <= cnt_ff;
      end
   end

   // Automatic gain reduction never raises the gain
   a_gain_down: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_last) && !$past(reset) |-> (gain_ff <= $past(gain_ff)))
      else $error("gain rose after clip reduction");

   // Peaks stay within full scale and nonzero after a block end
   a_end_peak: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec_en && op_ff == mgcpm_pkg::OP_END) |=>
      (lpk_ff <= PK_FS && lpk_ff != '0 && rpk_ff <= PK_FS && rpk_ff != '0))
      else $error("block end peak out of range");

   // Clipped output is full scale in magnitude
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      (cmd.post_en && need_in) |-> (vout == POS_FS || vout == NEG_FS))
      else $error("clip clamp wrong");

endmodule

FILE: rtl/core/master_gain_clip_peak_meter_core.sv
// Channel   Handshake        Payload
// req_bus   valid / ready    operation, left_in, right_in, volume, meter_was_read
// rsp_bus   valid / ready    left_out, right_out, gain_now, three peaks, clipped, pairs
// csr       csr_wr_en        csr_wr_data = decrease_on_clip
//
// A sample pair passes through the multiply, post and check states of the left
// channel, then those of the right channel, and then the done state. Each channel that clips with
// decrease-on-clip set adds the steps of the shared restoring divider, one gain bit
// per step. Other operations pass through an execute state and then the done state.
// One item is in work at a time.
// Synchronous reset restores gain 256, peaks 1, overall peak 0, flag and count 0.
// A finished result waits in the output register; the next item is accepted
// while it waits, and the block stalls only if that item finishes before it is taken.
module master_gain_clip_peak_meter_core #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   mgcpm_req_if.sink          req_bus,
   mgcpm_rsp_if.source        rsp_bus,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   mgcpm_pkg::cmd_type    cmd;
   mgcpm_pkg::status_type status;

   mgcpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mgcpm_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_operation        (req_bus.operation),
      .req_left_in          (req_bus.left_in),
      .req_right_in         (req_bus.right_in),
      .req_volume           (req_bus.volume),
      .req_meter_was_read   (req_bus.meter_was_read),
      .rsp_left_out         (rsp_bus.left_out),
      .rsp_right_out        (rsp_bus.right_out),
      .rsp_gain_now         (rsp_bus.gain_now),
      .rsp_left_peak_now    (rsp_bus.left_peak_now),
      .rsp_right_peak_now   (rsp_bus.right_peak_now),
      .rsp_overall_peak_now (rsp_bus.overall_peak_now),
      .rsp_clipped          (rsp_bus.clipped),
      .rsp_pairs_counted    (rsp_bus.pairs_counted)
   );

endmodule

FILE: tb/sv/master_gain_clip_peak_meter_core_test.sv
`timescale 1ns / 1ps

module master_gain_clip_peak_meter_core_test;

   localparam int SAMPLE_W    = 24;
   localparam int GAIN_W      = mgcpm_pkg::GAIN_W;
   localparam int OUT_W       = mgcpm_pkg::OUT_W;
   localparam int VOL_W       = mgcpm_pkg::VOL_W;
   localparam int PEAK_W      = mgcpm_pkg::PEAK_W;
   localparam int COUNT_W     = mgcpm_pkg::COUNT_W;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 3000;
   localparam int TAIL_CYCLES = 40;
   localparam int MID_RANGE   = 300000;
   localparam int RAND_ITEMS  = 105;
   localparam int PHASES      = 8;
   localparam longint GAIN_UNITY = longint'(1) << mgcpm_pkg::GAIN_FRAC_W;

   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [VOL_W-1:0]           VOL_MAX    = {VOL_W{1'b1}};

   typedef struct {
      logic signed [OUT_W-1:0] left_out;
      logic signed [OUT_W-1:0] right_out;
      logic [GAIN_W-1:0]       gain_now;
      logic [PEAK_W-1:0]       left_peak_now;
      logic [PEAK_W-1:0]       right_peak_now;
      logic [PEAK_W-1:0]       overall_peak_now;
      logic                    clipped;
      logic [COUNT_W-1:0]      pairs_counted;
   } mix_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic csr_wr_data;

   mgcpm_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_bus ();
   mgcpm_rsp_if rsp_bus ();

   master_gain_clip_peak_meter_core #(.SAMPLE_BITS(SAMPLE_W)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Mixer state as the block should hold it
   logic [GAIN_W-1:0]  mix_gain;
   logic [OUT_W-1:0]   mix_left_peak;
   logic [OUT_W-1:0]   mix_right_peak;
   logic [OUT_W-1:0]   mix_overall_peak;
   logic               mix_clip;
   logic [COUNT_W-1:0] mix_pairs;
   logic               mix_decrease;

   mix_result_type expected_mix[$];
   int errors;
   int max_gap;
   int max_stall;
   bit hold_request;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void reset_mixer();
      mix_gain         = mgcpm_pkg::GAIN_RESET;
      mix_left_peak    = 1;
      mix_right_peak   = 1;
      mix_overall_peak = '0;
      mix_clip         = 1'b0;
      mix_pairs        = '0;
      mix_decrease     = 1'b0;
   endfunction

   // Scale one sample, track its peak, lower the gain on a clip
   function automatic logic signed [OUT_W-1:0] scale_channel(
      input logic signed [SAMPLE_W-1:0] sample,
      input bit right_chan
   );
      longint x, g, v, mag, num;
      logic [OUT_W-1:0] pk;
      x = longint'(sample);
      g = longint'(mix_gain);
      v = (x * g) / GAIN_UNITY;
      if (v > mgcpm_pkg::OUT_LIMIT) v = mgcpm_pkg::OUT_LIMIT;
      if (v < -mgcpm_pkg::OUT_LIMIT) v = -mgcpm_pkg::OUT_LIMIT;
      mag = (v < 0) ? -v : v;
      pk = right_chan ? mix_right_peak : mix_left_peak;
      if (mag > longint'(pk)) pk = mag[OUT_W-1:0];
      if (right_chan) mix_right_peak = pk;
      else mix_left_peak = pk;
      if (mix_decrease && mag > mgcpm_pkg::FULL_SCALE) begin
         // round half up of gain * full scale / magnitude
         num = 2 * g * mgcpm_pkg::FULL_SCALE + mag;
         mix_gain = GAIN_W'(num / (2 * mag));
         v = (v < 0) ? -mgcpm_pkg::FULL_SCALE : mgcpm_pkg::FULL_SCALE;
      end
      return v[OUT_W-1:0];
   endfunction

   // Clamp a peak at block end, flag an overflow
   function automatic logic [OUT_W-1:0] settle_peak(input logic [OUT_W-1:0] pk);
      if (pk > OUT_W'(mgcpm_pkg::FULL_SCALE)) begin
         mix_clip = 1'b1;
         return OUT_W'(mgcpm_pkg::FULL_SCALE);
      end
      if (pk == '0) return OUT_W'(1);
      return pk;
   endfunction

   // Advance the mixer state by one accepted item and queue its result
   function automatic void predict_mix(
      input logic [2:0] op,
      input logic signed [SAMPLE_W-1:0] left_in,
      input logic signed [SAMPLE_W-1:0] right_in,
      input logic [VOL_W-1:0] volume,
      input logic meter_was_read
   );
      mix_result_type res;
      res.left_out  = '0;
      res.right_out = '0;
      unique case (op)
         mgcpm_pkg::OP_PAIR: begin
            res.left_out  = scale_channel(left_in, 1'b0);
            res.right_out = scale_channel(right_in, 1'b1);
            mix_pairs = mix_pairs + 1;
         end
         mgcpm_pkg::OP_VOL: begin
            mix_gain = GAIN_W'(volume);
         end
         mgcpm_pkg::OP_START: begin
            if (meter_was_read) begin
               mix_left_peak  = mix_left_peak >> 1;
               mix_right_peak = mix_right_peak >> 1;
            end
         end
         mgcpm_pkg::OP_END: begin
            mix_left_peak  = settle_peak(mix_left_peak);
            mix_right_peak = settle_peak(mix_right_peak);
            if (mix_left_peak > mix_overall_peak) mix_overall_peak = mix_left_peak;
            if (mix_right_peak > mix_overall_peak) mix_overall_peak = mix_right_peak;
         end
         mgcpm_pkg::OP_STOP: begin
            mix_clip  = 1'b0;
            mix_pairs = '0;
         end
         default: begin
         end
      endcase
      res.gain_now         = mix_gain;
      res.left_peak_now    = mix_left_peak[PEAK_W-1:0];
      res.right_peak_now   = mix_right_peak[PEAK_W-1:0];
      res.overall_peak_now = mix_overall_peak[PEAK_W-1:0];
      res.clipped          = mix_clip;
      res.pairs_counted    = mix_pairs;
      expected_mix.push_back(res);
   endfunction

   // Offer one item after a random gap, hold it until accepted
   task automatic send_item(
      input logic [2:0] op,
      input logic signed [SAMPLE_W-1:0] left_in,
      input logic signed [SAMPLE_W-1:0] right_in,
      input logic [VOL_W-1:0] volume,
      input logic meter_was_read
   );
      int gap;
      gap = (max_gap > 0) ? int'($urandom_range(0, max_gap)) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= op;
      req_bus.left_in        <= left_in;
      req_bus.right_in       <= right_in;
      req_bus.volume         <= volume;
      req_bus.meter_was_read <= meter_was_read;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      predict_mix(op, left_in, right_in, volume, meter_was_read);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      int unsigned pick;
      int s;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3, 4: return SAMPLE_W'($urandom());
         5, 6: begin
            s = int'($urandom_range(0, 2 * MID_RANGE)) - MID_RANGE;
            return s[SAMPLE_W-1:0];
         end
         default: begin
            s = int'($urandom_range(0, 2 * mgcpm_pkg::FULL_SCALE)) - mgcpm_pkg::FULL_SCALE;
            return s[SAMPLE_W-1:0];
         end
      endcase
   endfunction

   // Mostly sample pairs, with meter and volume traffic and a little noise
   task automatic send_random_item();
      int unsigned pick;
      logic [2:0] op;
      logic [VOL_W-1:0] volume;
      pick = $urandom_range(0, 99);
      if (pick < 62) op = mgcpm_pkg::OP_PAIR;
      else if (pick < 72) op = mgcpm_pkg::OP_VOL;
      else if (pick < 80) op = mgcpm_pkg::OP_START;
      else if (pick < 90) op = mgcpm_pkg::OP_END;
      else if (pick < 95) op = mgcpm_pkg::OP_STOP;
      else op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      if ($urandom_range(0, 3) == 0) volume = VOL_W'($urandom_range(0, VOL_MAX));
      else volume = VOL_W'($urandom_range(VOL_MAX / 2 + 1, VOL_MAX));
      send_item(op, draw_sample(), draw_sample(), volume, 1'($urandom()));
   endtask

   // Drop valid and wait until every queued result has come back
   task automatic drain_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_mix.size() != 0) @(posedge clock);
   endtask

   task automatic write_decrease(input logic value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      mix_decrease = value;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_result();
      mix_result_type want;
      if (expected_mix.size() == 0) begin
         $display("%0t: result with no item pending", $time);
         errors++;
      end else begin
         want = expected_mix[0];
         expected_mix.delete(0);
         check_field("left_out", longint'(want.left_out), longint'(rsp_bus.left_out));
         check_field("right_out", longint'(want.right_out), longint'(rsp_bus.right_out));
         check_field("gain_now", longint'(want.gain_now), longint'(rsp_bus.gain_now));
         check_field("left_peak_now", longint'(want.left_peak_now),
                     longint'(rsp_bus.left_peak_now));
         check_field("right_peak_now", longint'(want.right_peak_now),
                     longint'(rsp_bus.right_peak_now));
         check_field("overall_peak_now", longint'(want.overall_peak_now),
                     longint'(rsp_bus.overall_peak_now));
         check_field("clipped", longint'(want.clipped), longint'(rsp_bus.clipped));
         check_field("pairs_counted", longint'(want.pairs_counted),
                     longint'(rsp_bus.pairs_counted));
      end
   endtask

   // Result side: stall at random, or for a long stretch on request
   initial begin : result_sink
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = (max_stall > 0) ? int'($urandom_range(0, max_stall)) : 0;
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         check_result();
      end
   end

   // End the run when neither channel moves an item for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   // Each operation at field extremes, zero peaks at block end, unused codes
   task automatic test_basic_ops();
      logic [2:0] op;
      send_item(mgcpm_pkg::OP_START, '0, '0, '0, 1'b1);
      send_item(mgcpm_pkg::OP_END, '0, '0, '0, 1'b0);
      send_item(mgcpm_pkg::OP_PAIR, '0, '0, '0, 1'b0);
      send_item(mgcpm_pkg::OP_PAIR, SAMPLE_MAX, SAMPLE_MIN, VOL_MAX, 1'b1);
      send_item(mgcpm_pkg::OP_END, SAMPLE_MIN, SAMPLE_MAX, '0, 1'b0);
      send_item(mgcpm_pkg::OP_STOP, '0, '0, '0, 1'b0);
      send_item(mgcpm_pkg::OP_VOL, '0, '0, VOL_MAX, 1'b0);
      // truncation toward zero on both signs
      send_item(mgcpm_pkg::OP_PAIR, -24'sd1, 24'sd1, '0, 1'b0);
      send_item(mgcpm_pkg::OP_PAIR, -24'sd300, 24'sd300, '0, 1'b0);
      send_item(mgcpm_pkg::OP_VOL, '0, '0, '0, 1'b0);
      send_item(mgcpm_pkg::OP_PAIR, SAMPLE_MIN, SAMPLE_MAX, '0, 1'b0);
      for (op = OP_UNUSED_FIRST; op != mgcpm_pkg::OP_PAIR; op++)
         send_item(op, draw_sample(), draw_sample(), VOL_W'($urandom()), 1'($urandom()));
      drain_block();
   endtask

   // Gain reduction on clip; the right sample sees the gain the left one left
   task automatic test_clip_gain();
      write_decrease(1'b1);
      send_item(mgcpm_pkg::OP_VOL, '0, '0, VOL_MAX, 1'b0);
      send_item(mgcpm_pkg::OP_PAIR, SAMPLE_MAX, SAMPLE_MAX, '0, 1'b0);
      send_item(mgcpm_pkg::OP_PAIR, SAMPLE_MIN, 24'sd33000, '0, 1'b0);
      send_item(mgcpm_pkg::OP_VOL, '0, '0, 8'd200, 1'b0);
      send_item(mgcpm_pkg::OP_PAIR, 24'sd40000, -24'sd40000, '0, 1'b0);
      send_item(mgcpm_pkg::OP_PAIR, 24'sd60000, -24'sd60000, '0, 1'b0);
      drain_block();
      write_decrease(1'b0);
   endtask

   // Peak halving, block end with and without overflow, stop clears the flag
   task automatic test_peak_meter();
      send_item(mgcpm_pkg::OP_STOP, '0, '0, '0, 1'b0);
      send_item(mgcpm_pkg::OP_PAIR, 24'sd20000, -24'sd100, '0, 1'b0);
      send_item(mgcpm_pkg::OP_START, '0, '0, '0, 1'b1);
      send_item(mgcpm_pkg::OP_END, '0, '0, '0, 1'b0);
      send_item(mgcpm_pkg::OP_PAIR, 24'sd60000, 24'sd5, '0, 1'b0);
      send_item(mgcpm_pkg::OP_END, '0, '0, '0, 1'b0);
      send_item(mgcpm_pkg::OP_STOP, '0, '0, '0, 1'b1);
      drain_block();
   endtask

   // Keep offering items back to back while the result side holds off
   task automatic test_backpressure();
      max_gap = 0;
      hold_request = 1'b1;
      repeat (12) send_random_item();
      drain_block();
      max_gap = 19;
   endtask

   // Random traffic over several register settings and idling patterns
   task automatic test_random_mix();
      int phase;
      for (phase = 0; phase < PHASES; phase++) begin
         write_decrease((phase % 3) != 0);
         max_gap   = (phase == 2 || phase == 5) ? 0 : 19;
         max_stall = (phase == 2 || phase == 6) ? 0 : 19;
         repeat (RAND_ITEMS) send_random_item();
         drain_block();
      end
      max_gap   = 19;
      max_stall = 19;
   endtask

   initial begin : run_tests
      errors       = 0;
      max_gap      = 19;
      max_stall    = 19;
      hold_request = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      req_bus.valid          = 1'b0;
      req_bus.operation      = mgcpm_pkg::OP_PAIR;
      req_bus.left_in        = '0;
      req_bus.right_in       = '0;
      req_bus.volume         = '0;
      req_bus.meter_was_read = 1'b0;
      reset_mixer();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_clip_gain();
      test_peak_meter();
      test_backpressure();
      test_random_mix();

      drain_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_mix.size() != 0) errors++;
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
